[rtl/sms_pkg.sv]
// sms_pkg: payload types, command and status structs and constants
// of the softmax multinomial sampler; no dependencies
`timescale 1ns / 1ps

package sms_pkg;

	// log2(e) as Q1.16 and ln(2) as Q0.32
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;

	// weight that is forced to zero from this shift on
	localparam logic [8:0] SHIFT_LIMIT = 9'd17;

	typedef struct packed {
		logic signed [15:0] logit_value;
		logic [31:0]        token_id;
		logic [15:0]        random_fraction;
		logic               row_last;
	} item_t;

	typedef struct packed {
		logic [9:0]  sampled_index;
		logic [31:0] sampled_token;
		logic [16:0] sampled_weight;
		logic        row_overflow;
	} result_t;

	typedef struct packed {
		logic accept;
		logic exp_run;
		logic mul;
		logic scan_run;
		logic tok_read;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic exp_done;
		logic scan_done;
		logic out_busy;
	} sts_t;

endpackage

[rtl/sms_ram.sv]
// sms_ram: generic single write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module sms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sms_ctrl.sv]
// sms_ctrl: sequencer of the load, exp, multiply, scan and output phases
// depends on sms_pkg
`timescale 1ns / 1ps

module sms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          row_last,
	input  sms_pkg::sts_t sts,
	output logic          item_stall,
	output sms_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_EXP  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_TOK  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
				if (item_valid && row_last) begin
					state_d = ST_EXP;
				end
			end
			ST_EXP: begin
				cmd.exp_run = 1'b1;
				if (sts.exp_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_TOK;
				end
			end
			ST_TOK: begin
				cmd.tok_read = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/sms_datapath.sv]
// sms_datapath: row stores, running max, exp pipeline, sum, sampling scan
// and result register; depends on sms_pkg and sms_ram
`timescale 1ns / 1ps

module sms_datapath #(
	parameter int MAX_ROW_LEN       = 1024,
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sms_pkg::item_t   item,
	input  sms_pkg::cmd_t    cmd,
	output sms_pkg::sts_t    sts,
	output logic             result_valid,
	input  logic             result_stall,
	output sms_pkg::result_t result
);

	localparam int AW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
	localparam int CW = $clog2(MAX_ROW_LEN + 1);
	localparam int SW = 16 + CW;
	localparam int TW = $clog2(EXP_TABLE_ENTRIES);
	localparam int PW = 24 + TW + 1;

	typedef logic [16:0] tbl_t [EXP_TABLE_ENTRIES];

	// round(2^(-k/N) * 65536) from a Q32 series of exp(-z)
	function automatic logic [16:0] exp2_entry(input int unsigned k);
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] tot;
		z = (64'(k) * 64'(sms_pkg::LN2_Q32)) / EXP_TABLE_ENTRIES;
		term = 64'h1_0000_0000;
		pos = 64'h1_0000_0000;
		neg = 64'd0;
		for (int n = 1; n < 24; n++) begin
			term = (term * z) >> 32;
			term = term / 64'(n);
			if (n % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		tot = pos - neg + 64'd32768;
		return tot[32:16];
	endfunction

	function automatic tbl_t build_tbl();
		tbl_t t;
		for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
			t[k] = exp2_entry(k);
		end
		return t;
	endfunction

	localparam tbl_t EXP_TBL = build_tbl();

	// row state
	logic [CW-1:0]        count_q;
	logic signed [15:0]   max_q;
	logic                 ovf_q;
	logic [15:0]          rnd_q;
	logic [SW-1:0]        sum_q;
	logic [SW+15:0]       target_q;

	// exp pass
	logic [CW-1:0]        ia_q;
	logic                 exp_issue;
	logic                 v_s1;
	logic [AW-1:0]        a_s1;
	logic                 v_s2;
	logic [AW-1:0]        a_s2;
	logic [32:0]          t_s2;
	logic                 v_s3;
	logic [AW-1:0]        a_s3;
	logic [16:0]          w_s3;
	logic signed [15:0]   logit_rd;
	logic [15:0]          diff;
	logic [PW-1:0]        idx_prod;
	logic [TW-1:0]        tbl_idx;
	logic [8:0]           shift_n;
	logic [16:0]          w_calc;

	// scan pass
	logic [CW-1:0]        j_q;
	logic                 scan_issue;
	logic                 sv_s1;
	logic [AW-1:0]        sa_s1;
	logic [16:0]          w_rd;
	logic [SW-1:0]        cum_q;
	logic [SW-1:0]        cum_n;
	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [16:0]          pickw_q;
	logic [CW-1:0]        cnt_m1;
	logic [31:0]          tok_rd;

	logic                 store_wr;
	logic                 out_take;

	assign store_wr   = cmd.accept && (count_q < CW'(MAX_ROW_LEN));
	assign exp_issue  = cmd.exp_run && (ia_q < count_q);
	assign scan_issue = cmd.scan_run && (j_q < count_q) && !found_q;
	assign cnt_m1     = count_q - CW'(1);

	sms_ram #(.WIDTH(16), .DEPTH(MAX_ROW_LEN)) u_logit_ram (
		.clk   (clk),
		.we    (store_wr),
		.waddr (count_q[AW-1:0]),
		.wdata (item.logit_value),
		.re    (exp_issue),
		.raddr (ia_q[AW-1:0]),
		.rdata (logit_rd)
	);

	sms_ram #(.WIDTH(32), .DEPTH(MAX_ROW_LEN)) u_token_ram (
		.clk   (clk),
		.we    (store_wr),
		.waddr (count_q[AW-1:0]),
		.wdata (item.token_id),
		.re    (cmd.tok_read),
		.raddr (pick_q),
		.rdata (tok_rd)
	);

	sms_ram #(.WIDTH(17), .DEPTH(MAX_ROW_LEN)) u_weight_ram (
		.clk   (clk),
		.we    (v_s3),
		.waddr (a_s3),
		.wdata (w_s3),
		.re    (scan_issue),
		.raddr (j_q[AW-1:0]),
		.rdata (w_rd)
	);

	// exp stage arithmetic: distance from max, then table index and shift
	assign diff     = max_q - logit_rd;
	assign idx_prod = PW'(t_s2[23:0]) * PW'(EXP_TABLE_ENTRIES);
	assign tbl_idx  = idx_prod[24 +: TW];
	assign shift_n  = t_s2[32:24];
	assign w_calc   = (shift_n >= sms_pkg::SHIFT_LIMIT) ? 17'd0 :
		(EXP_TBL[tbl_idx] >> shift_n[4:0]);

	assign cum_n = cum_q + SW'(w_rd);

	always_ff @(posedge clk) begin
		a_s1 <= ia_q[AW-1:0];
		a_s2 <= a_s1;
		t_s2 <= 33'(diff) * 33'(sms_pkg::LOG2E_Q16);
		a_s3 <= a_s2;
		w_s3 <= w_calc;
		sa_s1 <= j_q[AW-1:0];
		if (cmd.accept && item.row_last) begin
			rnd_q <= item.random_fraction;
		end
		if (cmd.mul) begin
			target_q <= (SW+16)'(rnd_q) * (SW+16)'(sum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= 16'sh8000;
			ovf_q   <= 1'b0;
			sum_q   <= '0;
			ia_q    <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			sv_s1   <= 1'b0;
			cum_q   <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
			pickw_q <= '0;
		end else begin
			v_s1  <= exp_issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			sv_s1 <= scan_issue;
			if (store_wr) begin
				count_q <= count_q + CW'(1);
				if (item.logit_value > max_q) begin
					max_q <= item.logit_value;
				end
			end else if (cmd.accept) begin
				ovf_q <= 1'b1;
			end
			if (exp_issue) begin
				ia_q <= ia_q + CW'(1);
			end
			if (v_s3) begin
				sum_q <= sum_q + SW'(w_s3);
			end
			if (scan_issue) begin
				j_q <= j_q + CW'(1);
			end
			if (sv_s1 && !found_q) begin
				cum_q <= cum_n;
				if (({cum_n, 16'd0} > target_q) || (sa_s1 == cnt_m1[AW-1:0])) begin
					found_q <= 1'b1;
					pick_q  <= sa_s1;
					pickw_q <= w_rd;
				end
			end
			if (cmd.out_load) begin
				count_q <= '0;
				max_q   <= 16'sh8000;
				ovf_q   <= 1'b0;
				sum_q   <= '0;
				ia_q    <= '0;
				j_q     <= '0;
				cum_q   <= '0;
				found_q <= 1'b0;
			end
		end
	end

	// result register
	logic             res_valid_q;
	sms_pkg::result_t res_q;

	assign out_take = res_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (out_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.sampled_index  <= 10'(pick_q);
			res_q.sampled_token  <= tok_rd;
			res_q.sampled_weight <= pickw_q;
			res_q.row_overflow   <= ovf_q;
		end
	end

	assign result_valid  = res_valid_q;
	assign result        = res_q;
	assign sts.exp_done  = cmd.exp_run && (ia_q == count_q) && !v_s1 && !v_s2 && !v_s3;
	assign sts.scan_done = found_q;
	assign sts.out_busy  = res_valid_q && result_stall;

endmodule

[rtl/softmax_multinomial_sampler.sv]
// softmax_multinomial_sampler: top level, joins controller and datapath
// depends on sms_pkg, sms_ctrl, sms_datapath, sms_ram
`timescale 1ns / 1ps

// usage
// - item channel: one logit with its token id per transfer; the transfer
//   with row_last set closes the row and carries random_fraction
// - result channel: one transfer per row with the sampled index, token,
//   weight and the overflow flag
// - loading takes one cycle per item; items past MAX_ROW_LEN are dropped
//   and flagged
// - after the last item the exp pass (store read, multiply, table stage),
//   the multiply, the scan, the token read and the result load run in turn;
//   the passes walk the stored items one at a time, set by the single read
//   port per store
// - item_stall is high from the last item until the result is loaded; the
//   next row may load while a result still waits in the output register
// - a stalled result holds; a finished row waits for the output register
// - reset clears the row state and the result valid flag; the stores need
//   no clearing pass as only entries of the current row are read
module softmax_multinomial_sampler #(
	parameter int MAX_ROW_LEN       = 1024,
	parameter int EXP_TABLE_ENTRIES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sms_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output sms_pkg::result_t result
);

	// command and status between sequencer and datapath
	sms_pkg::cmd_t cmd;
	sms_pkg::sts_t sts;

	sms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.row_last   (item.row_last),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	sms_datapath #(
		.MAX_ROW_LEN       (MAX_ROW_LEN),
		.EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(result_valid && result_stall))
		else $error("result overwritten while stalled");

	// a loaded result shows up on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_valid)
		else $error("loaded result not valid");

	// items are taken only outside the exp and scan passes
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (!cmd.exp_run && !cmd.scan_run && !item_stall))
		else $error("item taken during a pass");
`endif

endmodule

[dv/softmax_multinomial_sampler_tb.sv]
// softmax_multinomial_sampler_tb: self-checking testbench of the softmax sampler
// depends on sms_pkg and softmax_multinomial_sampler; predicts each sampled result
`timescale 1ns / 1ps

module softmax_multinomial_sampler_tb;
	import sms_pkg::*;

	localparam int ROW_DEPTH   = 1024;
	localparam int TABLE_SIZE  = 256;
	localparam int STALL_LIMIT = 200000;

	// sender and receiver idling modes
	typedef enum logic [1:0] {
		IDLE_SEND_LIGHT,
		IDLE_SEND_HEAVY,
		IDLE_NONE
	} idle_mode_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	softmax_multinomial_sampler u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// predictor state: one row of logits and tokens, running max, overflow flag
	logic [31:0]        exp2_lut [TABLE_SIZE];
	logic signed [15:0] row_logits [ROW_DEPTH];
	logic [31:0]        row_tokens [ROW_DEPTH];
	int                 row_len;
	logic signed [15:0] row_max;
	logic               row_dropped;

	result_t    sample_queue [$];
	idle_mode_t idle_mode;
	int         mismatches;
	int         idle_cycles;
	logic       timed_out;

	// exp table entry: round(2^(-k/N) * 65536) from a Q32 series for exp(-z)
	function automatic logic [31:0] lut_entry(int k);
		logic [63:0] z, term, pos, neg;
		z    = (64'(k) * 64'(LN2_Q32)) / TABLE_SIZE;
		term = 64'd1 << 32;
		pos  = 64'd1 << 32;
		neg  = 64'd0;
		for (int n = 1; n < 24; n++) begin
			term = (term * z) >> 32;
			term = term / n;
			if (n % 2 == 1)
				neg += term;
			else
				pos += term;
		end
		return 32'(((pos - neg) + 64'd32768) >> 16);
	endfunction

	function automatic logic [16:0] exp_weight(logic signed [15:0] lg, logic signed [15:0] mx);
		logic [63:0] gap, t, shift, idx;
		gap   = 64'($unsigned(16'(mx - lg)));
		t     = gap * 64'(LOG2E_Q16);
		shift = t >> 24;
		idx   = ((t & 64'hFFFFFF) * TABLE_SIZE) >> 24;
		if (shift >= 64'(SHIFT_LIMIT))
			return 17'd0;
		return 17'(exp2_lut[idx] >> shift);
	endfunction

	// absorbs one accepted item; a closing item queues the expected sample
	task automatic predict_sample(item_t it);
		logic [16:0] w [ROW_DEPTH];
		logic [63:0] total, target, cum;
		int          pick;
		result_t     res;
		if (row_len < ROW_DEPTH) begin
			row_logits[row_len] = it.logit_value;
			row_tokens[row_len] = it.token_id;
			if (it.logit_value > row_max)
				row_max = it.logit_value;
			row_len++;
		end else begin
			row_dropped = 1'b1;
		end
		if (!it.row_last)
			return;
		total = 0;
		for (int i = 0; i < row_len; i++) begin
			w[i] = exp_weight(row_logits[i], row_max);
			total += w[i];
		end
		target = 64'(it.random_fraction) * total;
		cum    = 0;
		pick   = row_len - 1;
		for (int i = 0; i < row_len; i++) begin
			cum += w[i];
			if ((cum << 16) > target) begin
				pick = i;
				break;
			end
		end
		res.sampled_index  = 10'(pick);
		res.sampled_token  = row_tokens[pick];
		res.sampled_weight = w[pick];
		res.row_overflow   = row_dropped;
		sample_queue.push_back(res);
		row_len     = 0;
		row_max     = -16'sd32768;
		row_dropped = 1'b0;
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SEND_LIGHT: return $urandom_range(99) < 17;
			IDLE_SEND_HEAVY: return $urandom_range(99) < 46;
			default:         return 1'b0;
		endcase
	endfunction

	// one item transfer, holding the payload while stalled
	task automatic send_item(logic signed [15:0] lg, logic [31:0] tok,
			logic [15:0] rnd, logic last);
		item_t it;
		it.logit_value     = lg;
		it.token_id        = tok;
		it.random_fraction = rnd;
		it.row_last        = last;
		while (sender_idles()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_sample(it);
	endtask

	task automatic send_row(int len, int lo, int hi);
		for (int i = 0; i < len; i++)
			send_item(16'($signed($urandom_range(hi - lo) + lo)), $urandom(),
				16'($urandom()), i == len - 1);
	endtask

	task automatic wait_drain();
		item_valid <= 1'b0;
		while (sample_queue.size() != 0 && !timed_out)
			@(posedge clk);
	endtask

	// receiver stall, changed at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_SEND_LIGHT: result_stall <= $urandom_range(99) < 46;
				IDLE_SEND_HEAVY: result_stall <= $urandom_range(99) < 17;
				default:         result_stall <= 1'b0;
			endcase
		end
	end

	// result checker, compares each transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (sample_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				result_t exp_res;
				exp_res = sample_queue.pop_front();
				if (result !== exp_res) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_res, result);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("** softmax_multinomial_sampler: FAILED **");
			$finish;
		end
	end

	task automatic test_field_extremes();
		send_item(16'sh7FFF, 32'hFFFFFFFF, 16'h0000, 1'b1);
		send_item(-16'sd32768, 32'h0, 16'hFFFF, 1'b1);
		send_item(-16'sd32768, 32'h1, 16'h8000, 1'b0);
		send_item(16'sh7FFF, 32'hAAAA5555, 16'hFFFF, 1'b1);
		send_item(16'sd0, 32'h5555AAAA, 16'h5555, 1'b0);
		send_item(16'sd0, 32'h12345678, 16'hAAAA, 1'b0);
		send_item(16'sd0, 32'h9ABCDEF0, 16'hFFFF, 1'b1);
		send_item(16'sd256, 32'd7, 16'h0001, 1'b0);
		send_item(-16'sd300, 32'd8, 16'hFFFE, 1'b0);
		send_item(16'sd1024, 32'd9, 16'h7FFF, 1'b1);
		wait_drain();
	endtask

	// row past the store depth, with the closing item dropped
	task automatic test_row_overflow();
		send_row(ROW_DEPTH + 1, -32768, 32767);
		wait_drain();
	endtask

	task automatic test_random_rows(int items);
		int sent;
		int len;
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
			case ($urandom_range(3))
				0: send_row(len, -32768, 32767);
				1: send_row(len, -1024, 1024);
				2: send_row(len, 1000, 1200);
				default: send_row(len, -8, 8);
			endcase
			sent += len;
		end
	endtask

	initial begin
		for (int k = 0; k < TABLE_SIZE; k++)
			exp2_lut[k] = lut_entry(k);
		row_len      = 0;
		row_max      = -16'sd32768;
		row_dropped  = 1'b0;
		mismatches   = 0;
		idle_cycles  = 0;
		timed_out    = 1'b0;
		idle_mode    = IDLE_SEND_LIGHT;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_row_overflow();
		test_random_rows(140);
		// sender holds off until the block has drained
		wait_drain();
		idle_mode = IDLE_SEND_HEAVY;
		test_random_rows(140);
		idle_mode = IDLE_NONE;
		test_random_rows(140);
		wait_drain();
		repeat (50) @(posedge clk);

		if (mismatches == 0 && sample_queue.size() == 0)
			$display("** softmax_multinomial_sampler: PASSED **");
		else
			$display("** softmax_multinomial_sampler: FAILED **");
		$finish;
	end

endmodule

[files.f]
rtl/sms_pkg.sv
rtl/sms_ram.sv
rtl/sms_ctrl.sv
rtl/sms_datapath.sv
rtl/softmax_multinomial_sampler.sv
dv/softmax_multinomial_sampler_tb.sv
